### src/est_pkg.sv
package est_pkg;

  localparam int FLOOR_W = 5;
  localparam int DEFAULT_FLOOR_COUNT = 16;

  typedef enum logic [1:0] {
    ACT_NONE = 2'b00,
    ACT_MOVE = 2'b01,
    ACT_STOP = 2'b10
  } act_t;

  typedef enum logic [1:0] {
    DIR_STAY = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_t;

  localparam logic REQ_CALL = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic advance;
    logic commit;
    logic arrive;
    logic set_move;
    logic move;
    logic stay;
    logic load_out;
  } est_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic exhausted;
    logic at_pos;
    logic is_step;
    logic req_step;
    logic call_ok;
    logic out_free;
  } est_stat_t;

endpackage

### src/est_in_if.sv
interface est_in_if import est_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [FLOOR_W-1:0] floor;

  modport source (output valid, output req_type, output floor, input ready);
  modport sink (input valid, input req_type, input floor, output ready);
endinterface

### src/est_out_if.sv
interface est_out_if import est_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [FLOOR_W-1:0]        car_floor;
  logic [FLOOR_W-1:0]        goal_floor;
  logic signed [1:0]         heading;
  logic [FLOOR_W-1:0]        cleared_call;

  modport source (output valid, output action, output car_floor, output goal_floor,
                  output heading, output cleared_call, input ready);
  modport sink (input valid, input action, input car_floor, input goal_floor,
                input heading, input cleared_call, output ready);
endinterface

### src/est_dp.sv
module est_dp import est_pkg::*; #(
  parameter int FLOOR_COUNT = DEFAULT_FLOOR_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_type,
  input  logic [FLOOR_W-1:0] floor,
  input  est_cmd_t           cmd,
  output est_stat_t          stat,
  est_out_if.source          result
);

  localparam int IW = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
  localparam logic [IW-1:0] TOP_IDX = IW'(FLOOR_COUNT - 1);

  logic [FLOOR_COUNT-1:0] pending;
  logic [IW-1:0]          pos;
  logic [IW-1:0]          target;
  dir_t                   dir;
  logic [IW-1:0]          idx;
  logic                   scan_up;
  logic                   phase;
  logic                   is_step;
  act_t                   act;
  logic [FLOOR_W-1:0]     served;
  logic                   out_valid;

  logic                   call_ok;
  logic                   at_edge;
  logic [IW-1:0]          call_idx;
  logic [IW:0]            idx_plus;
  logic [IW:0]            pos_plus;
  logic [IW:0]            tgt_plus;

  assign call_ok  = (floor != '0) && (int'(floor) <= FLOOR_COUNT);
  assign call_idx = IW'(floor - 1'b1);
  assign at_edge  = scan_up ? (idx == TOP_IDX) : (idx == '0);
  assign idx_plus = {1'b0, idx} + 1'b1;
  assign pos_plus = {1'b0, pos} + 1'b1;
  assign tgt_plus = {1'b0, target} + 1'b1;

  assign stat.hit       = pending[idx];
  assign stat.exhausted = !pending[idx] && at_edge && phase;
  assign stat.at_pos    = (idx == pos);
  assign stat.is_step   = is_step;
  assign stat.req_step  = (req_type == REQ_STEP);
  assign stat.call_ok   = call_ok;
  assign stat.out_free  = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      pos       <= '0;
      target    <= '0;
      dir       <= DIR_UP;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        is_step <= req_type;
        act     <= ACT_NONE;
        served  <= '0;
        idx     <= pos;
        scan_up <= (dir == DIR_UP);
        phase   <= 1'b0;
        if (req_type == REQ_CALL && call_ok) begin
          pending[call_idx] <= 1'b1;
        end
      end
      if (cmd.advance) begin
        if (at_edge) begin
          phase   <= 1'b1;
          scan_up <= ~scan_up;
          idx     <= pos;
        end else begin
          idx <= scan_up ? idx_plus[IW-1:0] : idx - 1'b1;
        end
      end
      if (cmd.commit) begin
        dir    <= scan_up ? DIR_UP : DIR_DOWN;
        target <= idx;
      end
      if (cmd.arrive) begin
        pending[idx] <= 1'b0;
        served       <= FLOOR_W'(idx_plus);
        act          <= ACT_STOP;
        idx          <= pos;
        phase        <= 1'b0;
      end
      if (cmd.set_move) begin
        act <= ACT_MOVE;
      end
      if (cmd.move) begin
        pos <= scan_up ? pos_plus[IW-1:0] : pos - 1'b1;
      end
      if (cmd.stay) begin
        dir <= DIR_STAY;
      end
      if (cmd.load_out) begin
        out_valid           <= 1'b1;
        result.action       <= act;
        result.car_floor    <= FLOOR_W'(pos_plus);
        result.goal_floor   <= FLOOR_W'(tgt_plus);
        result.heading      <= $signed(dir);
        result.cleared_call <= served;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;

endmodule

### src/est_ctrl.sv
module est_ctrl import est_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  est_stat_t stat,
  output est_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESCAN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (stat.req_step || stat.call_ok) ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.commit = 1'b1;
          if (stat.at_pos) begin
            cmd.arrive = 1'b1;
            state_next = S_RESCAN;
          end else begin
            cmd.set_move = 1'b1;
            cmd.move     = stat.is_step;
            state_next   = S_EMIT;
          end
        end else if (stat.exhausted) begin
          cmd.stay   = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_RESCAN: begin
        if (stat.hit) begin
          cmd.commit = 1'b1;
          state_next = S_EMIT;
        end else if (stat.exhausted) begin
          cmd.stay   = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/elevator_target_scheduler_core.sv
// Elevator target scheduler.
// request: one transaction per event. req_type 0 is a floor call (floor 1..FLOOR_COUNT),
//   req_type 1 reports that the car finished its previous move or stop.
// result: exactly one transaction per request: action (0 nothing, 1 move, 2 arrived),
//   car floor, goal floor, heading (-1 down, 0 stay, 1 up) and the floor whose call
//   was served (0 if none).
// A request is taken only while the controller is idle. The target search walks the
// pending-call bitmap one floor per cycle, first in the travel direction from the car,
// then in the other direction; an arrival runs a second search. An ignored call goes
// to the output stage without a search; a new request is taken the cycle after the
// result is loaded into the output register.
// Reset (rst, synchronous) clears all calls, puts the car at floor 1 heading up with
// goal floor 1, and empties the output register.
// When the receiver stalls, the result is held in the output register; the next
// request is still accepted and processed, and its result waits for the register.
module elevator_target_scheduler_core import est_pkg::*; #(
  parameter int FLOOR_COUNT = DEFAULT_FLOOR_COUNT
) (
  input  logic      clk,
  input  logic      rst,
  est_in_if.sink    request,
  est_out_if.source result
);

  est_cmd_t  cmd;
  est_stat_t stat;
  logic      in_ready;

  assign request.ready = in_ready;

  est_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  est_dp #(
    .FLOOR_COUNT (FLOOR_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_type (request.req_type),
    .floor    (request.floor),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

endmodule
